FILE: src/cfhu_pkg.sv
// ============================================================================
// Package for the cylindrical H-field update core
// Shared constants and a signed saturation helper.
// ============================================================================
package cfhu_pkg;

	localparam int RadialCells = 256;
	localparam int AxialCells  = 256;
	localparam int FieldWidth  = 32;
	localparam int IndexWidth  = 8;
	localparam int DataWidth   = 32;
	localparam int CfgIndexWidth = 3;

	localparam logic [CfgIndexWidth-1:0] REG_COEF_AXIAL  = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_COEF_RADIAL = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_PRESET_HR   = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_PRESET_HPHI = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_PRESET_HZ   = 3'd4;

	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_PRESET = 1'b1;

	// Signed 64-bit saturation to a w-bit signed range.
	function automatic logic signed [63:0] clip_w(input logic signed [63:0] v,
			input int w, output logic sat);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		begin
			hi = (64'sd1 <<< (w - 1)) - 64'sd1;
			lo = -hi - 64'sd1;
			sat = 1'b0;
			clip_w = v;
			if (v > hi) begin
				clip_w = hi;
				sat = 1'b1;
			end else if (v < lo) begin
				clip_w = lo;
				sat = 1'b1;
			end
		end
	endfunction

endpackage

FILE: src/cfhu_mul.sv
// ============================================================================
// Rounding multiplier
// Registered signed-by-unsigned product with round-half-up at two scales.
// ============================================================================
module cfhu_mul #(
	parameter int DW = 34,
	parameter int SHIFT = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] d,
	input  logic        [31:0]   c,
	output logic signed [63:0]   full_s1,
	output logic signed [63:0]   half_s1
);
	logic signed [DW+33:0] prod;
	logic signed [DW+33:0] rf;
	logic signed [DW+33:0] rh;

	// Adding half a unit and then taking the floor gives round-half-up.
	always_comb begin
		prod = $signed(d) * $signed({1'b0, c});
		rf = (prod + ($signed({{(DW+33){1'b0}}, 1'b1}) <<< (SHIFT - 1))) >>> SHIFT;
		rh = (prod + ($signed({{(DW+33){1'b0}}, 1'b1}) <<< SHIFT)) >>> (SHIFT + 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			full_s1 <= 64'(rf);
			half_s1 <= 64'(rh);
		end
	end
endmodule

FILE: src/cylindrical_fdtd_h_update_core.sv
// ============================================================================
// Cylindrical FDTD H-field update core
// Updates Hr, Hphi and Hz of one r-z mesh cell per transfer.
// ============================================================================
// Usage: each input transfer names a cell and carries its electric samples.
// Mode update reads the three stored H values of the cell, adds the curl
// terms and writes the full-step values back; mode preset writes the preset
// registers into the cell. Each input transfer gives one output transfer.
// Throughput is one item per cycle when not stalled, set by the six-stage
// register pipeline and one-read/one-write ports of the three field memories.
// Back-to-back updates of the same cell are forwarded from later stages.
// Configuration is to be written through the cfg channel while the core is
// idle; the core does not check this, and cfg_ready is always high.
// After reset the core clears its field memories, one cell a cycle, over all
// RADIAL_CELLS*AXIAL_CELLS cells; in_stall stays high for that time.
// A stall on a valid output freezes the whole pipeline; nothing is lost.
// ============================================================================
module cylindrical_fdtd_h_update_core #(
	parameter int RADIAL_CELLS = cfhu_pkg::RadialCells,
	parameter int AXIAL_CELLS  = cfhu_pkg::AxialCells,
	parameter int FIELD_WIDTH  = cfhu_pkg::FieldWidth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  radial_index,
	input  logic [7:0]  axial_index,
	input  logic signed [31:0] ephi_here,
	input  logic signed [31:0] ephi_next_axial,
	input  logic signed [31:0] ephi_next_radial,
	input  logic signed [31:0] ez_here,
	input  logic signed [31:0] ez_next_radial,
	input  logic signed [31:0] er_here,
	input  logic signed [31:0] er_next_axial,
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [31:0] hr_full,
	output logic signed [31:0] hr_half,
	output logic signed [31:0] hphi_full,
	output logic signed [31:0] hphi_half,
	output logic signed [31:0] hz_full,
	output logic signed [31:0] hz_half,
	output logic        radial_only,
	output logic        saturated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int RW = $clog2(RADIAL_CELLS);
	localparam int KW = $clog2(AXIAL_CELLS);
	localparam int AW = RW + KW;
	localparam int DEPTH = RADIAL_CELLS * AXIAL_CELLS;
	localparam int FW = FIELD_WIDTH;

	// ---------------- configuration ----------------
	logic [31:0] coef_axial_q, coef_radial_q;
	logic signed [31:0] preset_hr_q, preset_hphi_q, preset_hz_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_axial_q <= '0;
			coef_radial_q <= '0;
			preset_hr_q <= '0;
			preset_hphi_q <= '0;
			preset_hz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cfhu_pkg::REG_COEF_AXIAL:  coef_axial_q <= cfg_data;
				cfhu_pkg::REG_COEF_RADIAL: coef_radial_q <= cfg_data;
				cfhu_pkg::REG_PRESET_HR:   preset_hr_q <= cfg_data;
				cfhu_pkg::REG_PRESET_HPHI: preset_hphi_q <= cfg_data;
				cfhu_pkg::REG_PRESET_HZ:   preset_hz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- clearing pass ----------------
	logic clr_q;
	logic [AW:0] clr_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == (AW+1)'(DEPTH - 1)) clr_q <= 1'b0;
		end
	end

	// ---------------- pipeline control ----------------
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	assign adv = !(v_s6 && out_stall);
	assign in_stall = clr_q || !adv;
	logic acc;
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// ---------------- stage 1: decode, differences ----------------
	logic mode_s1, inb_s1, last_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0] ri_s1;
	logic signed [32:0] d_hr_s1, d_ez_s1, d_er_s1, sum_ep_s1, d_ep_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= mode;
			ri_s1 <= radial_index;
			if (mode == cfhu_pkg::MODE_PRESET)
				inb_s1 <= (32'(radial_index) < RADIAL_CELLS) &&
					(32'(axial_index) < AXIAL_CELLS);
			else
				inb_s1 <= (32'(radial_index) < RADIAL_CELLS) &&
					(32'(axial_index) < AXIAL_CELLS - 1);
			last_s1 <= 32'(radial_index) == RADIAL_CELLS - 1;
			addr_s1 <= AW'((32'(radial_index) * AXIAL_CELLS) + 32'(axial_index));
			d_hr_s1 <= 33'(ephi_next_axial) - 33'(ephi_here);
			d_ez_s1 <= 33'(ez_next_radial) - 33'(ez_here);
			d_er_s1 <= 33'(er_next_axial) - 33'(er_here);
			sum_ep_s1 <= 33'(ephi_next_radial) + 33'(ephi_here);
			d_ep_s1 <= 33'(ephi_next_radial) - 33'(ephi_here);
		end
	end

	// ---------------- stage 2: first products ----------------
	// Reciprocal of 2i+1 in unsigned Q1.31, rounded, as a constant table.
	logic [31:0] recip_rom [256];
	for (genvar g = 0; g < 256; g++) begin : g_recip
		localparam logic [33:0] RecipQ = (34'h1_0000_0000 / (2 * g + 1)) + 34'd1;
		assign recip_rom[g] = RecipQ[32:1];
	end

	logic signed [63:0] p_hr_f, p_hr_h, p_ez_f, p_ez_h, p_er_f, p_er_h, p_t, p_t_unused;
	logic [31:0] recip;
	assign recip = recip_rom[ri_s1];
	cfhu_mul #(.DW(33), .SHIFT(32)) u_mhr (.clk, .en(adv), .d(d_hr_s1), .c(coef_axial_q),
		.full_s1(p_hr_f), .half_s1(p_hr_h));
	cfhu_mul #(.DW(33), .SHIFT(32)) u_mez (.clk, .en(adv), .d(d_ez_s1), .c(coef_radial_q),
		.full_s1(p_ez_f), .half_s1(p_ez_h));
	cfhu_mul #(.DW(33), .SHIFT(32)) u_mer (.clk, .en(adv), .d(d_er_s1), .c(coef_axial_q),
		.full_s1(p_er_f), .half_s1(p_er_h));
	cfhu_mul #(.DW(33), .SHIFT(31)) u_mt (.clk, .en(adv), .d(sum_ep_s1), .c(recip),
		.full_s1(p_t), .half_s1(p_t_unused));

	logic mode_s2, inb_s2, last_s2;
	logic [AW-1:0] addr_s2;
	logic signed [32:0] d_ep_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1; inb_s2 <= inb_s1; last_s2 <= last_s1;
			addr_s2 <= addr_s1; d_ep_s2 <= d_ep_s1;
		end
	end

	// ---------------- stage 3: Hz product, memory read ----------------
	logic signed [34:0] g_s2;
	assign g_s2 = 35'(p_t) + 35'(d_ep_s2);
	logic signed [63:0] p_g_f, p_g_h;
	cfhu_mul #(.DW(35), .SHIFT(32)) u_mg (.clk, .en(adv), .d(g_s2), .c(coef_radial_q),
		.full_s1(p_g_f), .half_s1(p_g_h));

	logic [FW-1:0] hr_mem [DEPTH];
	logic [FW-1:0] hp_mem [DEPTH];
	logic [FW-1:0] hz_mem [DEPTH];
	logic [FW-1:0] hr_rd_s3, hp_rd_s3, hz_rd_s3;
	logic mode_s3, inb_s3, last_s3;
	logic [AW-1:0] addr_s3;
	logic signed [63:0] inc_hr_f_s3, inc_hr_h_s3, inc_hp_f_s3, inc_hp_h_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			hr_rd_s3 <= hr_mem[addr_s2];
			hp_rd_s3 <= hp_mem[addr_s2];
			hz_rd_s3 <= hz_mem[addr_s2];
			mode_s3 <= mode_s2; inb_s3 <= inb_s2; last_s3 <= last_s2;
			addr_s3 <= addr_s2;
			inc_hr_f_s3 <= p_hr_f; inc_hr_h_s3 <= p_hr_h;
			inc_hp_f_s3 <= p_ez_f - p_er_f; inc_hp_h_s3 <= p_ez_h - p_er_h;
		end
	end

	// ---------------- stage 4: add, saturate, write back ----------------
	// Writes of stages 4..6 are forwarded over the memory read; those of stages 4 and 5 are newer than it.
	logic wr_s4, wr_s5, wr_s6;
	logic wrp_s4, wrp_s5, wrp_s6;
	logic [AW-1:0] waddr_s4, waddr_s5, waddr_s6;
	logic signed [FW-1:0] whr_s4, whp_s4, whz_s4, whr_s5, whp_s5, whz_s5;
	logic signed [FW-1:0] whr_s6, whp_s6, whz_s6;
	logic signed [FW-1:0] ohr, ohp, ohz;

	always_comb begin
		ohr = hr_rd_s3; ohp = hp_rd_s3; ohz = hz_rd_s3;
		if (wr_s6 && waddr_s6 == addr_s3) begin
			ohr = whr_s6;
			if (wrp_s6) begin ohp = whp_s6; ohz = whz_s6; end
		end
		if (wr_s5 && waddr_s5 == addr_s3) begin
			ohr = whr_s5;
			if (wrp_s5) begin ohp = whp_s5; ohz = whz_s5; end
		end
		if (v_s4 && wr_s4 && waddr_s4 == addr_s3) begin
			ohr = whr_s4;
			if (wrp_s4) begin ohp = whp_s4; ohz = whz_s4; end
		end
	end

	logic signed [63:0] nhr_f, nhr_h, nhp_f, nhp_h, nhz_f, nhz_h, phr, php, phz;
	logic s0, s1, s2, s3, s4, s5, s6, s7, s8, sat_c;
	always_comb begin
		nhr_f = cfhu_pkg::clip_w(64'(ohr) + inc_hr_f_s3, FW, s0);
		nhr_h = cfhu_pkg::clip_w(64'(ohr) + inc_hr_h_s3, FW, s1);
		nhp_f = cfhu_pkg::clip_w(64'(ohp) + inc_hp_f_s3, FW, s2);
		nhp_h = cfhu_pkg::clip_w(64'(ohp) + inc_hp_h_s3, FW, s3);
		nhz_f = cfhu_pkg::clip_w(64'(ohz) - p_g_f, FW, s4);
		nhz_h = cfhu_pkg::clip_w(64'(ohz) - p_g_h, FW, s5);
		phr = cfhu_pkg::clip_w(64'(preset_hr_q), FW, s6);
		php = cfhu_pkg::clip_w(64'(preset_hphi_q), FW, s7);
		phz = cfhu_pkg::clip_w(64'(preset_hz_q), FW, s8);
		if (mode_s3 == cfhu_pkg::MODE_PRESET) sat_c = s6 | s7 | s8;
		else if (last_s3) sat_c = s0 | s1;
		else sat_c = s0 | s1 | s2 | s3 | s4 | s5;
	end

	logic [31:0] hrf_d, hrh_d, hpf_d, hph_d, hzf_d, hzh_d;
	logic ro_d, sat_d;
	logic signed [FW-1:0] whr_d, whp_d, whz_d;
	always_comb begin
		hrf_d = '0; hrh_d = '0; hpf_d = '0; hph_d = '0; hzf_d = '0; hzh_d = '0;
		ro_d = 1'b0; sat_d = 1'b0;
		whr_d = ohr; whp_d = ohp; whz_d = ohz;
		if (inb_s3) begin
			if (mode_s3 == cfhu_pkg::MODE_PRESET) begin
				whr_d = FW'(phr); whp_d = FW'(php); whz_d = FW'(phz);
				hrf_d = phr[31:0]; hrh_d = phr[31:0];
				hpf_d = php[31:0]; hph_d = php[31:0];
				hzf_d = phz[31:0]; hzh_d = phz[31:0];
				sat_d = sat_c;
			end else begin
				whr_d = FW'(nhr_f);
				hrf_d = nhr_f[31:0]; hrh_d = nhr_h[31:0];
				sat_d = sat_c;
				if (last_s3) ro_d = 1'b1;
				else begin
					whp_d = FW'(nhp_f); whz_d = FW'(nhz_f);
					hpf_d = nhp_f[31:0]; hph_d = nhp_h[31:0];
					hzf_d = nhz_f[31:0]; hzh_d = nhz_h[31:0];
				end
			end
		end
	end

	logic [31:0] o_hrf, o_hrh, o_hpf, o_hph, o_hzf, o_hzh;
	logic o_ro, o_sat;
	always_ff @(posedge clk) begin
		if (adv) begin
			wr_s4 <= v_s3 && inb_s3;
			wrp_s4 <= (mode_s3 == cfhu_pkg::MODE_PRESET) || !last_s3;
			waddr_s4 <= addr_s3;
			o_hrf <= hrf_d; o_hrh <= hrh_d; o_hpf <= hpf_d; o_hph <= hph_d;
			o_hzf <= hzf_d; o_hzh <= hzh_d;
			o_ro <= ro_d; o_sat <= sat_d;
			whr_s4 <= whr_d; whp_s4 <= whp_d; whz_s4 <= whz_d;
		end
	end

	// Memory write port: clearing pass, else the stage 4 write on advance.
	always_ff @(posedge clk) begin
		if (clr_q) begin
			hr_mem[clr_cnt_q[AW-1:0]] <= '0;
			hp_mem[clr_cnt_q[AW-1:0]] <= '0;
			hz_mem[clr_cnt_q[AW-1:0]] <= '0;
		end else if (adv && v_s4 && wr_s4) begin
			hr_mem[waddr_s4] <= whr_s4;
			if (wrp_s4) begin
				hp_mem[waddr_s4] <= whp_s4;
				hz_mem[waddr_s4] <= whz_s4;
			end
		end
	end

	// ---------------- stages 5 and 6: forwarding history, output ----------------
	logic [31:0] r5_hrf, r5_hrh, r5_hpf, r5_hph, r5_hzf, r5_hzh;
	logic r5_ro, r5_sat;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s5 <= 1'b0; wr_s6 <= 1'b0;
		end else if (adv) begin
			wr_s5 <= v_s4 && wr_s4;
			wr_s6 <= wr_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			wrp_s5 <= wrp_s4; waddr_s5 <= waddr_s4;
			whr_s5 <= whr_s4; whp_s5 <= whp_s4; whz_s5 <= whz_s4;
			wrp_s6 <= wrp_s5; waddr_s6 <= waddr_s5;
			whr_s6 <= whr_s5; whp_s6 <= whp_s5; whz_s6 <= whz_s5;
			r5_hrf <= o_hrf; r5_hrh <= o_hrh; r5_hpf <= o_hpf; r5_hph <= o_hph;
			r5_hzf <= o_hzf; r5_hzh <= o_hzh; r5_ro <= o_ro; r5_sat <= o_sat;
			hr_full <= r5_hrf; hr_half <= r5_hrh; hphi_full <= r5_hpf;
			hphi_half <= r5_hph; hz_full <= r5_hzf; hz_half <= r5_hzh;
			radial_only <= r5_ro; saturated <= r5_sat;
		end
	end
	assign out_valid = v_s6;

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !acc) else $error("item taken during clearing pass");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(hr_full)))
		else $error("result changed under stall");
	a_ro_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && radial_only) |-> (hphi_full == 32'd0 && hz_full == 32'd0))
		else $error("radial-only result carries Hphi or Hz");
`endif
endmodule
